[rtl/lpmf_pkg.sv]
// Package with the types, widths and codes of the lidar point mask projection filter.
`default_nettype none

package lpmf_pkg;

  localparam int MASK_COLS_MAX = 1024;
  localparam int MASK_ROWS_MAX = 512;
  localparam int MASK_DEPTH    = MASK_COLS_MAX * MASK_ROWS_MAX;
  localparam int MASK_AW       = $clog2(MASK_DEPTH);

  localparam int COEFF_NUM = 12;
  localparam int ROT_NUM   = 9;
  localparam int COEFF_AW  = $clog2(COEFF_NUM);

  // Datapath widths: rotation products, camera coordinates, magnitudes,
  // partial products, dividends and quotient bits.
  localparam int PRW  = 52;
  localparam int CW   = 54;
  localparam int MW   = 53;
  localparam int LO   = 27;
  localparam int PPW  = 32 + LO;
  localparam int NW   = 87;
  localparam int QB   = 27;
  localparam int FRAC = 16;
  localparam int PIXW = 12;

  typedef enum logic [1:0] {
    OP_MASK  = 2'd0,
    OP_COEFF = 2'd1,
    OP_POINT = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_FOCAL_X        = 3'd0,
    CFG_FOCAL_Y        = 3'd1,
    CFG_CENTRE_X       = 3'd2,
    CFG_CENTRE_Y       = 3'd3,
    CFG_MASK_WIDTH     = 3'd4,
    CFG_MASK_HEIGHT    = 3'd5,
    CFG_GRAY_THRESHOLD = 3'd6
  } cfg_e;

  typedef struct packed {
    op_e                op;
    logic [9:0]         pixel_col;
    logic [8:0]         pixel_row;
    logic [7:0]         gray_value;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic               point_finite;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] kept_x;
    logic signed [19:0] kept_y;
    logic signed [19:0] kept_z;
    logic [9:0]         image_u;
    logic [8:0]         image_v;
  } out_item_t;

  // What every pipeline stage carries along with its arithmetic.
  typedef struct packed {
    op_e                op;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [9:0]         col;
    logic [8:0]         row;
    logic               mask_bit;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic             neg_x;
    logic             neg_y;
    logic [MW-1:0]    den;
    logic [NW-1:0]    rem_x;
    logic [NW-1:0]    rem_y;
    logic [QB-1:0]    quo_x;
    logic [QB-1:0]    quo_y;
  } dstage_t;

endpackage

`default_nettype wire

[rtl/lidar_point_mask_projection_filter.sv]
// Lidar point filter: camera transform, pinhole projection and mask lookup in one pipeline.
// Throughput: one item per cycle while the skid stage is empty; the 27 stages of restoring division and the one-port
// mask memory each handle one item a cycle.
// Stall: the output has a register and a skid stage; the pipeline halts only while both hold.
// Reset: configuration takes its reset values; the mask and coefficient stores are not cleared.
`default_nettype none

module lidar_point_mask_projection_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpmf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpmf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import lpmf_pkg::*;

  function automatic dstage_t div_step(dstage_t s, int k);
    dstage_t       r;
    logic [NW-1:0] dsh;
    r   = s;
    dsh = NW'(s.den) << k;
    if (s.rem_x >= dsh) begin
      r.rem_x = s.rem_x - dsh;
      r.quo_x = {s.quo_x[QB-2:0], 1'b1};
    end else begin
      r.quo_x = {s.quo_x[QB-2:0], 1'b0};
    end
    if (s.rem_y >= dsh) begin
      r.rem_y = s.rem_y - dsh;
      r.quo_y = {s.quo_y[QB-2:0], 1'b1};
    end else begin
      r.quo_y = {s.quo_y[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [MASK_AW-1:0] mask_addr(logic [8:0] row, logic [9:0] col);
    return MASK_AW'(row) * MASK_AW'(MASK_COLS_MAX) + MASK_AW'(col);
  endfunction

  // Configuration registers.
  logic [31:0] focal_x_q, focal_y_q, centre_x_q, centre_y_q;
  logic [10:0] width_q;
  logic [9:0]  height_q;
  logic [7:0]  thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= '0;
      focal_y_q  <= '0;
      centre_x_q <= '0;
      centre_y_q <= '0;
      width_q    <= 11'd1024;
      height_q   <= 10'd512;
      thr_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FOCAL_X:        focal_x_q  <= cfg_data_i;
        CFG_FOCAL_Y:        focal_y_q  <= cfg_data_i;
        CFG_CENTRE_X:       centre_x_q <= cfg_data_i;
        CFG_CENTRE_Y:       centre_y_q <= cfg_data_i;
        CFG_MASK_WIDTH:     width_q    <= cfg_data_i[10:0];
        CFG_MASK_HEIGHT:    height_q   <= cfg_data_i[9:0];
        CFG_GRAY_THRESHOLD: thr_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless the skid stage is occupied.
  logic en, accept;
  logic skid_valid_q, out_valid_q;
  out_item_t out_q, skid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && en;

  // Transform coefficients.
  logic signed [31:0] coeff_q [COEFF_NUM];

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.op == OP_COEFF && 32'(in_data_i.coeff_index) < COEFF_NUM) begin
      coeff_q[in_data_i.coeff_index[COEFF_AW-1:0]] <= in_data_i.coeff_value;
    end
  end

  // Stage 1: input register.
  side_t side_in, side1_q;
  logic  alive_in;

  always_comb begin
    side_in.op       = in_data_i.op;
    side_in.x        = in_data_i.point_x;
    side_in.y        = in_data_i.point_y;
    side_in.z        = in_data_i.point_z;
    side_in.col      = in_data_i.pixel_col;
    side_in.row      = in_data_i.pixel_row;
    side_in.mask_bit = in_data_i.gray_value > thr_q;
    unique case (in_data_i.op)
      OP_MASK:  alive_in = 32'(in_data_i.pixel_col) < MASK_COLS_MAX &&
                           32'(in_data_i.pixel_row) < MASK_ROWS_MAX;
      OP_POINT: alive_in = in_data_i.point_finite;
      default:  alive_in = 1'b0;
    endcase
  end

  // Stage 2: rotation products and translation.
  logic signed [19:0]  pt1 [3];
  logic signed [PRW-1:0] prod_q [ROT_NUM];
  logic signed [31:0]  trans_q [3];
  side_t side2_q;

  assign pt1[0] = side1_q.x;
  assign pt1[1] = side1_q.y;
  assign pt1[2] = side1_q.z;

  // Stage 3: camera-frame coordinates in Q.16 mm.
  logic signed [CW-1:0] cam_q [3];
  side_t side3_q;

  // Stage 4: magnitudes and depth.
  logic [MW-1:0] mag_x_q, mag_y_q, den4_q;
  logic neg_x4_q, neg_y4_q;
  side_t side4_q;

  // Stage 5: partial products of the projection numerators.
  logic [PPW-1:0] fxl_q, fxh_q, cxl_q, cxh_q, fyl_q, fyh_q, cyl_q, cyh_q;
  logic [MW-1:0] den5_q;
  logic neg_x5_q, neg_y5_q;
  side_t side5_q;

  // Stage 6: the two terms of each numerator.
  logic [NW-1:0] ax_q, bx_q, ay_q, by_q;
  logic [MW-1:0] den6_q;
  logic neg_x6_q, neg_y6_q;
  side_t side6_q;

  // Division stages; entry 0 holds the dividend.
  dstage_t ds_in;
  dstage_t ds_q [QB+1];

  always_comb begin
    ds_in.side  = side6_q;
    ds_in.den   = den6_q;
    ds_in.quo_x = '0;
    ds_in.quo_y = '0;
    if (!neg_x6_q) begin
      ds_in.rem_x = ax_q + bx_q;
      ds_in.neg_x = 1'b0;
    end else if (bx_q < ax_q) begin
      ds_in.rem_x = ax_q - bx_q;
      ds_in.neg_x = 1'b1;
    end else begin
      ds_in.rem_x = bx_q - ax_q;
      ds_in.neg_x = 1'b0;
    end
    if (!neg_y6_q) begin
      ds_in.rem_y = ay_q + by_q;
      ds_in.neg_y = 1'b0;
    end else if (by_q < ay_q) begin
      ds_in.rem_y = ay_q - by_q;
      ds_in.neg_y = 1'b1;
    end else begin
      ds_in.rem_y = by_q - ay_q;
      ds_in.neg_y = 1'b0;
    end
  end

  // A quotient of 2^27 or more can never land inside the mask.
  logic fits;
  assign fits = ds_q[0].rem_x < (NW'(ds_q[0].den) << QB) &&
                ds_q[0].rem_y < (NW'(ds_q[0].den) << QB);

  // Rounding and bounds check.
  logic [PIXW-1:0] mx, my;
  logic [31:0] wlim, hlim;
  logic ok_x, ok_y;
  side_t side_r_q;
  logic [9:0] u_r_q;
  logic [8:0] v_r_q;

  assign mx   = PIXW'(ds_q[QB].quo_x[QB-1:FRAC]) + PIXW'(ds_q[QB].quo_x[FRAC-1]);
  assign my   = PIXW'(ds_q[QB].quo_y[QB-1:FRAC]) + PIXW'(ds_q[QB].quo_y[FRAC-1]);
  assign wlim = 32'(width_q) < MASK_COLS_MAX ? 32'(width_q) : 32'(MASK_COLS_MAX);
  assign hlim = 32'(height_q) < MASK_ROWS_MAX ? 32'(height_q) : 32'(MASK_ROWS_MAX);
  assign ok_x = !(ds_q[QB].neg_x && mx != '0) && 32'(mx) < wlim;
  assign ok_y = !(ds_q[QB].neg_y && my != '0) && 32'(my) < hlim;

  // Mask memory stage: a mask write and a point lookup share one port.
  logic mask_mem [MASK_DEPTH];
  logic rd_q;
  logic [MASK_AW-1:0] maddr;
  logic is_mask;
  side_t side_m_q;
  logic [9:0] u_m_q;
  logic [8:0] v_m_q;

  assign is_mask = side_r_q.op == OP_MASK;
  assign maddr   = is_mask ? mask_addr(side_r_q.row, side_r_q.col) : mask_addr(v_r_q, u_r_q);

  // Per-stage flags: the stage holds an item that still has work to do.
  logic a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, ar_q, am_q;
  logic ads_q [QB+1];
  logic emit;

  assign emit = am_q && rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q <= 1'b0;
      a2_q <= 1'b0;
      a3_q <= 1'b0;
      a4_q <= 1'b0;
      a5_q <= 1'b0;
      a6_q <= 1'b0;
      ar_q <= 1'b0;
      am_q <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        ads_q[j] <= 1'b0;
      end
    end else if (en) begin
      a1_q     <= accept && alive_in;
      a2_q     <= a1_q;
      a3_q     <= a2_q;
      a4_q     <= a3_q && (side3_q.op != OP_POINT ||
                           (!cam_q[2][CW-1] && cam_q[2] != '0));
      a5_q     <= a4_q;
      a6_q     <= a5_q;
      ads_q[0] <= a6_q;
      ads_q[1] <= ads_q[0] && (ds_q[0].side.op != OP_POINT || fits);
      for (int j = 1; j < QB; j++) begin
        ads_q[j+1] <= ads_q[j];
      end
      ar_q <= ads_q[QB] && (ds_q[QB].side.op != OP_POINT || (ok_x && ok_y));
      am_q <= ar_q && side_r_q.op == OP_POINT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side_in;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i*3+j] <= coeff_q[i*3+j] * pt1[j];
        end
        trans_q[i] <= coeff_q[ROT_NUM+i];
      end
      side2_q <= side1_q;

      for (int i = 0; i < 3; i++) begin
        cam_q[i] <= CW'(prod_q[i*3]) + CW'(prod_q[i*3+1]) + CW'(prod_q[i*3+2]) +
                    CW'($signed({trans_q[i], 16'h0000}));
      end
      side3_q <= side2_q;

      neg_x4_q <= cam_q[0][CW-1];
      neg_y4_q <= cam_q[1][CW-1];
      mag_x_q  <= MW'(cam_q[0][CW-1] ? -cam_q[0] : cam_q[0]);
      mag_y_q  <= MW'(cam_q[1][CW-1] ? -cam_q[1] : cam_q[1]);
      den4_q   <= MW'(cam_q[2]);
      side4_q  <= side3_q;

      fxl_q    <= PPW'(focal_x_q) * PPW'(mag_x_q[LO-1:0]);
      fxh_q    <= PPW'(focal_x_q) * PPW'(mag_x_q[MW-1:LO]);
      cxl_q    <= PPW'(centre_x_q) * PPW'(den4_q[LO-1:0]);
      cxh_q    <= PPW'(centre_x_q) * PPW'(den4_q[MW-1:LO]);
      fyl_q    <= PPW'(focal_y_q) * PPW'(mag_y_q[LO-1:0]);
      fyh_q    <= PPW'(focal_y_q) * PPW'(mag_y_q[MW-1:LO]);
      cyl_q    <= PPW'(centre_y_q) * PPW'(den4_q[LO-1:0]);
      cyh_q    <= PPW'(centre_y_q) * PPW'(den4_q[MW-1:LO]);
      den5_q   <= den4_q;
      neg_x5_q <= neg_x4_q;
      neg_y5_q <= neg_y4_q;
      side5_q  <= side4_q;

      ax_q     <= NW'(fxl_q) + (NW'(fxh_q) << LO);
      bx_q     <= NW'(cxl_q) + (NW'(cxh_q) << LO);
      ay_q     <= NW'(fyl_q) + (NW'(fyh_q) << LO);
      by_q     <= NW'(cyl_q) + (NW'(cyh_q) << LO);
      den6_q   <= den5_q;
      neg_x6_q <= neg_x5_q;
      neg_y6_q <= neg_y5_q;
      side6_q  <= side5_q;

      ds_q[0] <= ds_in;
      for (int j = 0; j < QB; j++) begin
        ds_q[j+1] <= div_step(ds_q[j], QB - 1 - j);
      end

      side_r_q <= ds_q[QB].side;
      u_r_q    <= mx[9:0];
      v_r_q    <= my[8:0];

      side_m_q <= side_r_q;
      u_m_q    <= u_r_q;
      v_m_q    <= v_r_q;
    end
  end

  // Mask store; the write and the read of one item happen in the same stage,
  // so items see every earlier write in order.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ar_q && is_mask) begin
        mask_mem[maddr] <= side_r_q.mask_bit;
      end
      rd_q <= mask_mem[maddr];
    end
  end

  // Output register with skid stage.
  out_item_t res;

  assign res.kept_x  = side_m_q.x;
  assign res.kept_y  = side_m_q.y;
  assign res.kept_z  = side_m_q.z;
  assign res.image_u = u_m_q;
  assign res.image_v = v_m_q;

  // A new result can only arrive while the skid stage is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en && emit) begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_valid_q && !out_stall_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit) begin
      if (!out_valid_q || !out_stall_i) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_valid_q && !out_stall_i && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[dv/lidar_point_mask_projection_filter_tb.sv]
// Self-checking testbench for the lidar point mask projection filter.
`timescale 1ns / 100ps

module lidar_point_mask_projection_filter_tb;
  import lpmf_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 5000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  lidar_point_mask_projection_filter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the filter's configuration and stores.
  logic [31:0]        focal_x, focal_y, centre_x, centre_y;
  int                 mask_w, mask_h, gray_thr;
  logic signed [31:0] coef [COEFF_NUM];
  bit                 mask_bits [MASK_DEPTH];
  bit                 mask_seen [MASK_DEPTH];
  out_item_t          kept_q [$];

  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic bit project_axis(input logic [31:0] f, input logic [31:0] ctr,
                                      input longint num, input longint den,
                                      input int lim, output int pix);
    logic [127:0] a, b, n, q, m;
    logic [63:0]  mag;
    bit           neg;
    neg = 1'b0;
    pix = 0;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    a = 128'(f) * 128'(mag);
    b = 128'(ctr) * 128'(den);
    if (num >= 0) n = a + b;
    else if (b < a) begin
      n = a - b;
      neg = 1'b1;
    end else n = b - a;
    q = n / 128'(den);
    if (q[127:64] != 0) return 1'b0;
    m = (q >> 16) + 128'(q[15]);
    // A negative projection survives only when it rounds to pixel zero.
    if (neg && m != 0) return 1'b0;
    if (m >= 128'(lim)) return 1'b0;
    pix = int'(m);
    return 1'b1;
  endfunction

  // True when the point lands inside the mask; u and v give the pixel.
  function automatic bit locate_point(input in_item_t it, output int u, output int v);
    longint p [3];
    longint c [3];
    int     wl, hl;
    u = 0;
    v = 0;
    if (!it.point_finite) return 1'b0;
    p[0] = it.point_x;
    p[1] = it.point_y;
    p[2] = it.point_z;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'(coef[9 + i]) * 65536;
      for (int j = 0; j < 3; j++) c[i] += longint'(coef[i * 3 + j]) * p[j];
    end
    if (c[2] <= 0) return 1'b0;
    wl = (mask_w < MASK_COLS_MAX) ? mask_w : MASK_COLS_MAX;
    hl = (mask_h < MASK_ROWS_MAX) ? mask_h : MASK_ROWS_MAX;
    if (!project_axis(focal_x, centre_x, c[0], c[2], wl, u)) return 1'b0;
    if (!project_axis(focal_y, centre_y, c[1], c[2], hl, v)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void commit_item(input in_item_t it);
    int        u, v, addr;
    out_item_t res;
    case (it.op)
      OP_MASK: begin
        addr = int'(it.pixel_row) * MASK_COLS_MAX + int'(it.pixel_col);
        mask_bits[addr] = (int'(it.gray_value) > gray_thr);
        mask_seen[addr] = 1'b1;
      end
      OP_COEFF: begin
        if (it.coeff_index < COEFF_NUM) coef[it.coeff_index] = it.coeff_value;
      end
      OP_POINT: begin
        if (locate_point(it, u, v) && mask_bits[v * MASK_COLS_MAX + u]) begin
          res.kept_x  = it.point_x;
          res.kept_y  = it.point_y;
          res.kept_z  = it.point_z;
          res.image_u = 10'(u);
          res.image_v = 9'(v);
          kept_q.insert(kept_q.size(), res);
        end
      end
      default: ;
    endcase
  endfunction

  // The sender idles in tx_idle_pct of its cycles before presenting a transaction.
  task automatic push_transaction(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    commit_item(it);
  endtask

  // A point that would look up a never-written pixel gets that pixel written first.
  task automatic send_item(input in_item_t it);
    in_item_t mw;
    int       u, v;
    if (it.op == OP_POINT && locate_point(it, u, v) && !mask_seen[v * MASK_COLS_MAX + u]) begin
      mw = in_item_t'({$urandom, $urandom, $urandom, $urandom});
      mw.op        = OP_MASK;
      mw.pixel_col = 10'(u);
      mw.pixel_row = 9'(v);
      push_transaction(mw);
    end
    push_transaction(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    wait (kept_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FOCAL_X:        focal_x  = data;
      CFG_FOCAL_Y:        focal_y  = data;
      CFG_CENTRE_X:       centre_x = data;
      CFG_CENTRE_Y:       centre_y = data;
      CFG_MASK_WIDTH:     mask_w   = int'(data[10:0]);
      CFG_MASK_HEIGHT:    mask_h   = int'(data[9:0]);
      CFG_GRAY_THRESHOLD: gray_thr = int'(data[7:0]);
      default: ;
    endcase
  endtask

  task automatic program_camera(input logic [31:0] fx, input logic [31:0] fy,
                                input logic [31:0] cx, input logic [31:0] cy,
                                input int w, input int h, input int thr);
    settle();
    write_reg(CFG_FOCAL_X, fx);
    write_reg(CFG_FOCAL_Y, fy);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_MASK_WIDTH, 32'(w));
    write_reg(CFG_MASK_HEIGHT, 32'(h));
    write_reg(CFG_GRAY_THRESHOLD, 32'(thr));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_coeff(input int idx, input logic [31:0] val);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.op          = OP_COEFF;
    it.coeff_index = 4'(idx);
    it.coeff_value = val;
    return it;
  endfunction

  function automatic in_item_t make_point(input int x, input int y, input int z,
                                          input bit fin);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.op           = OP_POINT;
    it.point_x      = 20'(x);
    it.point_y      = 20'(y);
    it.point_z      = 20'(z);
    it.point_finite = fin;
    return it;
  endfunction

  // Point in front of the camera, spread over roughly the field of view.
  function automatic in_item_t scene_point();
    int z;
    z = $urandom_range(300, 20000);
    return make_point($urandom_range(0, z) - z / 2, $urandom_range(0, z) - z / 2, z,
                      ($urandom_range(99) < 95));
  endfunction

  // Near-identity rotation and a small translation keep the scene in view.
  function automatic logic [31:0] scene_coeff(input int idx);
    if (idx >= ROT_NUM) return 32'($urandom_range(0, 400) - 200);
    if (idx % 4 == 0) return 32'(65536 + $urandom_range(0, 2000) - 1000);
    return 32'($urandom_range(0, 2000) - 1000);
  endfunction

  task automatic load_scene_transform();
    for (int i = 0; i < COEFF_NUM; i++) send_item(make_coeff(i, scene_coeff(i)));
  endtask

  task automatic test_directed();
    in_item_t it;
    program_camera(32'd512 << 16, 32'd256 << 16, 32'd512 << 16, 32'd256 << 16,
                   MASK_COLS_MAX, MASK_ROWS_MAX, 100);
    for (int i = 0; i < COEFF_NUM; i++)
      send_item(make_coeff(i, (i < ROT_NUM && i % 4 == 0) ? 32'd65536 : 32'd0));
    // Indices beyond the translation are ignored.
    send_item(make_coeff(15, 32'h8000_0000));
    send_item(make_coeff(12, 32'h7fff_ffff));
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.op = OP_NOP;
    send_item(it);
    it.op = OP_MASK;
    it.pixel_col = 10'd1023; it.pixel_row = 9'd511; it.gray_value = 8'd255;
    send_item(it);
    it.pixel_col = 10'd0; it.pixel_row = 9'd0; it.gray_value = 8'd0;
    send_item(it);
    send_item(make_point(0, 0, 1000, 1'b1));
    send_item(make_point(0, 0, 1000, 1'b0));
    send_item(make_point(100, 100, 0, 1'b1));
    send_item(make_point(100, 100, -1000, 1'b1));
    send_item(make_point(-524288, 0, 524287, 1'b1));
    send_item(make_point(524287, -524288, 1000, 1'b1));
    send_item(make_point(-1, -1, 524287, 1'b1));
    send_item(make_point(200, -100, 1000, 1'b1));
  endtask

  task automatic test_random_stream(input int n_items, input int tx_pct, input int rx_pct);
    in_item_t it;
    int       sel;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    load_scene_transform();
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(99);
      if (sel < 62) it = scene_point();
      else if (sel < 72) begin
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.op = OP_POINT;
      end else if (sel < 84) begin
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.op = OP_MASK;
      end else if (sel < 92) begin
        it = make_coeff($urandom_range(0, COEFF_NUM - 1), 0);
        it.coeff_value = scene_coeff(it.coeff_index);
      end else it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
      send_item(it);
      // Repair a wild coefficient now and then so the scene stays in view.
      if (it.op == OP_COEFF && it.coeff_index < COEFF_NUM && sel >= 92)
        send_item(make_coeff(it.coeff_index, scene_coeff(it.coeff_index)));
    end
  endtask

  task automatic test_mask_bounds();
    // Zero width drops every point; the largest focal x and centre values overflow.
    program_camera(32'hffff_ffff, 32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, 0, 1023, 255);
    test_random_stream(40, 0, 0);
    // A one-pixel mask: small negative projections round onto pixel zero.
    program_camera(32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 1, 1, 0);
    test_random_stream(60, 0, 0);
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < rx_stall_pct);

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected x=%0d y=%0d z=%0d u=%0d v=%0d got x=%0d y=%0d z=%0d u=%0d v=%0d",
               $realtime, what, want.kept_x, want.kept_y, want.kept_z, want.image_u,
               want.image_v, got.kept_x, got.kept_y, got.kept_z, got.image_u, got.image_v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kept_q.size() == 0) report_mismatch("unexpected point", '0, out_data_o);
      else if (kept_q[0].kept_x !== out_data_o.kept_x || kept_q[0].kept_y !== out_data_o.kept_y ||
               kept_q[0].kept_z !== out_data_o.kept_z ||
               kept_q[0].image_u !== out_data_o.image_u ||
               kept_q[0].image_v !== out_data_o.image_v) begin
        report_mismatch("point mismatch", kept_q[0], out_data_o);
        void'(kept_q.pop_front());
      end else void'(kept_q.pop_front());
    end
  end

  // Ends the run when no transaction has moved on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    focal_x = '0; focal_y = '0; centre_x = '0; centre_y = '0;
    mask_w = MASK_COLS_MAX; mask_h = MASK_ROWS_MAX; gray_thr = 0;
    for (int i = 0; i < COEFF_NUM; i++) coef[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    program_camera(32'd1024 << 16 | 32'($urandom_range(0, 65535)), 32'd512 << 16,
                   32'd512 << 16, 32'd256 << 16, MASK_COLS_MAX, MASK_ROWS_MAX, 128);
    test_random_stream(220, 27, 66);
    program_camera(32'd900 << 16, 32'd450 << 16 | 32'($urandom_range(0, 65535)),
                   32'd500 << 16, 32'd250 << 16, 2047, 1023, 0);
    test_random_stream(220, 66, 27);
    program_camera(32'd37 << 16, 32'd20 << 16, 32'd18 << 16 | 32'h8000, 32'd10 << 16,
                   37, 20, $urandom_range(1, 254));
    test_random_stream(170, 0, 0);
    test_mask_bounds();
    settle();
    if (mismatches == 0 && kept_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
